// ----- rtl/core/rgb_image_point_filter_assert.svh -----
// assertion macros used by the point filter checker
// no dependencies; every macro takes the clock and reset to sample on
`ifndef RGB_IMAGE_POINT_FILTER_ASSERT_SVH
`define RGB_IMAGE_POINT_FILTER_ASSERT_SVH

// same-cycle implication
`define RGBIPF_AST_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RGBIPF_AST_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rgbipf_pkg.sv -----
// shared constants and types of the rgb point filter
// no dependencies
`default_nettype none

package rgbipf_pkg;

  localparam int MAX_PIXELS = 65536;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int PIX_W      = 24;

  localparam logic [1:0] MODE_GRAY    = 2'd0;
  localparam logic [1:0] MODE_STRETCH = 2'd1;
  localparam logic [1:0] MODE_NORM    = 2'd2;

  localparam logic [10:0] THIRD_MUL   = 11'd683;
  localparam int          THIRD_SHIFT = 11;

  typedef struct packed {
    logic        start;
    logic [15:0] num;
    logic [9:0]  den;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/rgbipf_ram.sv -----
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module rgbipf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/rgbipf_div.sv -----
// iterative 16 by 10 bit divider with an 8-bit saturating quotient, two bits a cycle
// depends on rgbipf_pkg
`default_nettype none

module rgbipf_div (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rgbipf_pkg::div_req_t req,
  output rgbipf_pkg::div_rsp_t      rsp
);

  localparam logic [1:0] STEP_LAST = 2'd3;

  logic       running;
  logic       done;
  logic [1:0] step_cnt;
  logic       sat;
  logic [9:0] den;
  logic [9:0] rem;
  logic [7:0] num_lo;
  logic [7:0] quo;

  logic [10:0] r1;
  logic [10:0] r2;
  logic        ge1;
  logic        ge2;
  logic [10:0] r1_sub;
  logic [10:0] r2_sub;
  logic [9:0]  rem1;
  logic [9:0]  rem2;

  always_comb begin
    r1     = {rem, num_lo[7]};
    ge1    = r1 >= {1'b0, den};
    r1_sub = ge1 ? (r1 - {1'b0, den}) : r1;
    rem1   = r1_sub[9:0];
    r2     = {rem1, num_lo[6]};
    ge2    = r2 >= {1'b0, den};
    r2_sub = ge2 ? (r2 - {1'b0, den}) : r2;
    rem2   = r2_sub[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running  <= 1'b1;
        step_cnt <= '0;
      end else if (running) begin
        step_cnt <= step_cnt + 2'd1;
        if (step_cnt == STEP_LAST) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den    <= req.den;
      rem    <= {2'b00, req.num[15:8]};
      num_lo <= req.num[7:0];
      quo    <= '0;
      sat    <= {2'b00, req.num} >= {req.den, 8'd0};
    end else if (running) begin
      rem    <= rem2;
      num_lo <= {num_lo[5:0], 2'b00};
      quo    <= {quo[5:0], ge1, ge2};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = sat ? 8'hFF : quo;

endmodule

`default_nettype wire

// ----- rtl/core/rgb_image_point_filter.sv -----
// top level of the rgb point filter: pixel buffer, frame statistics, emit sequencer
// depends on rgbipf_pkg, rgbipf_ram, rgbipf_div
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+------------------------
//  input    | kind, red_in, green_in, blue_in               | start high, busy low
//  result   | red_out, green_out, blue_out, last_pixel,     | done high for one cycle
//           | none_left, overflowed                         |
//  config   | cfg_wdata (filter mode)                       | cfg_we high
//
// a load is stored at acceptance and busy stays low
// an emit raises done after the buffer read, operand setup, four two-bit divider
// steps and result capture, with busy high until done rises
// an emit with nothing left raises done in the next cycle
// rst is synchronous; the pixel buffer is not cleared and needs no pass after reset
// the receiver cannot stall, results go out as they finish
`default_nettype none

module rgb_image_point_filter (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       kind,
  input  wire logic [7:0] red_in,
  input  wire logic [7:0] green_in,
  input  wire logic [7:0] blue_in,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  output logic            done,
  output logic      [7:0] red_out,
  output logic      [7:0] green_out,
  output logic      [7:0] blue_out,
  output logic            last_pixel,
  output logic            none_left,
  output logic            overflowed
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_PREP = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  localparam int CNT_W  = rgbipf_pkg::CNT_W;
  localparam int ADDR_W = rgbipf_pkg::ADDR_W;

  logic [1:0]       state;
  logic [1:0]       filter_mode;
  logic [CNT_W-1:0] pixel_count;
  logic [CNT_W-1:0] emit_index;
  logic [7:0]       ch_min [3];
  logic [7:0]       ch_max [3];
  logic             ovf_flag;
  logic             emitting;

  logic [7:0] pix [3];
  logic [9:0] sum;
  logic [7:0] gray;

  logic                    accept;
  logic [7:0]              in_px [3];
  logic [CNT_W-1:0]        base_count;
  logic                    full;
  logic                    wr_en;
  logic [rgbipf_pkg::PIX_W-1:0] rd_data;
  logic                    empty;
  logic [20:0]             gray_prod;

  rgbipf_pkg::div_req_t div_req [3];
  rgbipf_pkg::div_rsp_t div_rsp [3];
  logic [7:0]           res [3];

  assign busy   = state != ST_IDLE;
  assign accept = start && !busy;

  assign in_px[0] = red_in;
  assign in_px[1] = green_in;
  assign in_px[2] = blue_in;

  assign base_count = emitting ? '0 : pixel_count;
  assign full       = base_count == CNT_W'(rgbipf_pkg::MAX_PIXELS);
  assign wr_en      = accept && !kind && !full;
  assign empty      = emit_index >= pixel_count;
  assign gray_prod  = {11'd0, sum} * {10'd0, rgbipf_pkg::THIRD_MUL};

  rgbipf_ram #(
    .WIDTH(rgbipf_pkg::PIX_W),
    .DEPTH(rgbipf_pkg::MAX_PIXELS)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(base_count[ADDR_W-1:0]),
    .wdata({red_in, green_in, blue_in}),
    .raddr(emit_index[ADDR_W-1:0]),
    .rdata(rd_data)
  );

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [7:0] diff;
    logic [7:0] span;
    logic       at_or_above;

    assign at_or_above = pix[c] >= ch_min[c];
    assign diff        = pix[c] - ch_min[c];
    assign span        = ch_max[c] - ch_min[c];

    always_comb begin
      div_req[c].start = state == ST_PREP;
      if (filter_mode == rgbipf_pkg::MODE_STRETCH) begin
        div_req[c].num = at_or_above ? ({diff, 8'd0} - {8'd0, diff}) : 16'd0;
        div_req[c].den = {2'b00, span};
      end else begin
        div_req[c].num = {pix[c], 8'd0} - {8'd0, pix[c]};
        div_req[c].den = sum;
      end
    end

    rgbipf_div u_div (
      .clk(clk),
      .rst(rst),
      .req(div_req[c]),
      .rsp(div_rsp[c])
    );

    always_comb begin
      case (filter_mode)
        rgbipf_pkg::MODE_GRAY: begin
          res[c] = gray;
        end
        rgbipf_pkg::MODE_STRETCH: begin
          if (ch_max[c] <= ch_min[c]) begin
            res[c] = pix[c];
          end else if (!at_or_above) begin
            res[c] = '0;
          end else begin
            res[c] = div_rsp[c].quo;
          end
        end
        rgbipf_pkg::MODE_NORM: begin
          res[c] = (sum != '0) ? div_rsp[c].quo : pix[c];
        end
        default: begin
          res[c] = pix[c];
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      filter_mode <= rgbipf_pkg::MODE_GRAY;
      pixel_count <= '0;
      emit_index  <= '0;
      ovf_flag    <= 1'b0;
      emitting    <= 1'b0;
      done        <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        ch_min[c] <= 8'hFF;
        ch_max[c] <= 8'h00;
      end
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        filter_mode <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (accept && !kind) begin
            emitting <= 1'b0;
            if (emitting) begin
              emit_index <= '0;
            end
            ovf_flag <= (emitting ? 1'b0 : ovf_flag) | full;
            if (!full) begin
              pixel_count <= base_count + CNT_W'(1);
            end
            for (int c = 0; c < 3; c++) begin
              if (emitting) begin
                ch_min[c] <= in_px[c];
                ch_max[c] <= in_px[c];
              end else if (!full) begin
                if (in_px[c] < ch_min[c]) begin
                  ch_min[c] <= in_px[c];
                end
                if (in_px[c] > ch_max[c]) begin
                  ch_max[c] <= in_px[c];
                end
              end
            end
          end else if (accept) begin
            emitting <= 1'b1;
            if (empty) begin
              done <= 1'b1;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_PREP;
        end
        ST_PREP: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp[0].done) begin
            done       <= 1'b1;
            emit_index <= emit_index + CNT_W'(1);
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      pix[0] <= rd_data[23:16];
      pix[1] <= rd_data[15:8];
      pix[2] <= rd_data[7:0];
      sum    <= {2'b00, rd_data[23:16]} + {2'b00, rd_data[15:8]} + {2'b00, rd_data[7:0]};
    end
    if (state == ST_PREP) begin
      gray <= gray_prod[rgbipf_pkg::THIRD_SHIFT+7:rgbipf_pkg::THIRD_SHIFT];
    end
    if (state == ST_IDLE && accept && kind && empty) begin
      red_out    <= '0;
      green_out  <= '0;
      blue_out   <= '0;
      last_pixel <= 1'b0;
      none_left  <= 1'b1;
      overflowed <= ovf_flag;
    end else if (state == ST_DIV && div_rsp[0].done) begin
      red_out    <= res[0];
      green_out  <= res[1];
      blue_out   <= res[2];
      last_pixel <= (emit_index + CNT_W'(1)) == pixel_count;
      none_left  <= 1'b0;
      overflowed <= ovf_flag;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rgbipf_checker.sv -----
// port-level checker for the rgb point filter, bound to the top level
// depends on rgb_image_point_filter_assert.svh
`default_nettype none

`include "rgb_image_point_filter_assert.svh"

module rgbipf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       kind,
  input wire logic       done,
  input wire logic [7:0] red_out,
  input wire logic [7:0] green_out,
  input wire logic [7:0] blue_out,
  input wire logic       last_pixel,
  input wire logic       none_left
);

  `RGBIPF_AST_NXT(a_load_no_beat, clk, rst, start && !busy && !kind, !done, "load gave a beat")
  `RGBIPF_AST_NXT(a_emit_moves, clk, rst, start && !busy && kind, busy || done, "emit stalled")
  `RGBIPF_AST_IMP(a_empty_zero, clk, rst, done && none_left, red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0 && !last_pixel, "empty beat carries data")
  `RGBIPF_AST_IMP(a_busy_no_beat, clk, rst, busy, !done, "beat while busy")

endmodule

bind rgb_image_point_filter rgbipf_checker u_rgbipf_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .kind      (kind),
  .done      (done),
  .red_out   (red_out),
  .green_out (green_out),
  .blue_out  (blue_out),
  .last_pixel(last_pixel),
  .none_left (none_left)
);

`default_nettype wire
